// ===== rtl/scbpa_pkg.sv =====
// ============================================================================
// Size-class buffer pool allocator: shared definitions
// Constants, codes and the structures that pass between the front end, the
// command queue and the execution back end.
// ============================================================================
package scbpa_pkg;

    // Pool and buffer geometry.
    localparam int MAX_POOLS   = 4;
    localparam int MAX_BUFFERS = 64;
    localparam int SLOTS       = MAX_POOLS * MAX_BUFFERS;
    localparam int POOL_W      = $clog2(MAX_POOLS);
    localparam int BUF_W       = $clog2(MAX_BUFFERS);
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(MAX_BUFFERS + 1);

    // Field widths of the configuration registers and the request word.
    localparam int ACT_W   = 3;
    localparam int SIZE_W  = 16;
    localparam int CAP_W   = 8;
    localparam int SIZES_W = 64;
    localparam int CAPS_W  = 32;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 2;
    localparam int STAT_W  = 3;

    // Depth of the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indices.
    localparam logic [IDX_W-1:0] REG_POOLS_IN_USE = 2'd0;
    localparam logic [IDX_W-1:0] REG_BYTE_SIZES   = 2'd1;
    localparam logic [IDX_W-1:0] REG_BUF_COUNTS   = 2'd2;

    typedef enum logic [1:0] {
        OP_INIT       = 2'd0,
        OP_ALLOC_POOL = 2'd1,
        OP_ALLOC_SIZE = 2'd2,
        OP_RELEASE    = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_POOL  = 3'd1,
        ST_NONE_FREE = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_NOT_OWNED = 3'd4
    } status_t;

    // Decoded pool configuration: active pool count and saturated capacities.
    typedef struct packed {
        logic [ACT_W-1:0]                  active;
        logic [MAX_POOLS-1:0][CNT_W-1:0]   cap;
    } pool_cfg_t;

    // Classified request word as held in the command queue.
    typedef struct packed {
        op_t                 op;
        logic [POOL_W-1:0]   pool;
        logic [BUF_W-1:0]    bidx;
        logic                look;
        logic                bad_pool;
        logic                bad_index;
        logic [MAX_POOLS-1:0] fits;
    } cmd_t;

endpackage

// ===== rtl/scbpa_front.sv =====
// ============================================================================
// Size-class buffer pool allocator: front end
// Decodes the configuration and classifies each request word: pool range
// check, buffer index check and the set of pools large enough for a size.
// ============================================================================
module scbpa_front
    import scbpa_pkg::*;
(
    input  logic [ACT_W-1:0]   pools_in_use,
    input  logic [SIZES_W-1:0] pool_byte_sizes,
    input  logic [CAPS_W-1:0]  pool_buffer_counts,
    input  logic [1:0]         operation,
    input  logic [POOL_W-1:0]  pool_index,
    input  logic [SIZE_W-1:0]  size_request,
    input  logic               look_to_next,
    input  logic [BUF_W-1:0]   buffer_index,
    output pool_cfg_t          pcfg,
    output cmd_t               cmd
);

    logic [ACT_W-1:0]      active;
    logic [CAP_W-1:0]      raw_cap;
    logic [SIZE_W-1:0]     psize;
    logic [MAX_POOLS-1:0]  fits;

    // Active pool count is clamped to the number of pools built.
    assign active = (pools_in_use > ACT_W'(MAX_POOLS)) ? ACT_W'(MAX_POOLS) : pools_in_use;

    // Per-pool capacity, saturated, and size fit against the request.
    always_comb
    begin
        pcfg.active = active;
        fits        = '0;
        raw_cap     = '0;
        psize       = '0;
        pcfg.cap    = '0;
        for (int p = 0; p < MAX_POOLS; p++)
        begin
            raw_cap = pool_buffer_counts[CAP_W*p +: CAP_W];
            psize   = pool_byte_sizes[SIZE_W*p +: SIZE_W];
            pcfg.cap[p] = (raw_cap > CAP_W'(MAX_BUFFERS)) ? CNT_W'(MAX_BUFFERS)
                                                          : CNT_W'(raw_cap);
            fits[p] = (ACT_W'(p) < active) && (psize >= size_request);
        end
    end

    // Request checks that depend on configuration alone.
    always_comb
    begin
        cmd.op        = op_t'(operation);
        cmd.pool      = pool_index;
        cmd.bidx      = buffer_index;
        cmd.look      = look_to_next;
        cmd.bad_pool  = !(ACT_W'(pool_index) < active);
        cmd.bad_index = CNT_W'(buffer_index) >= pcfg.cap[pool_index];
        cmd.fits      = fits;
    end

endmodule

// ===== rtl/scbpa_queue.sv =====
// ============================================================================
// Size-class buffer pool allocator: command queue
// A short first-in-first-out queue of classified words that lets the front
// end keep accepting while the back end is busy.
// ============================================================================
module scbpa_queue
    import scbpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    cmd_t                store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0]  fill_reg, fill_next;

    assign full    = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_cmd   = store_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/scbpa_back.sv =====
// ============================================================================
// Size-class buffer pool allocator: back end
// Executes queued words against the free stacks, free counts and owned
// flags, and holds the result word until it is taken.
// ============================================================================
module scbpa_back
    import scbpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pool_cfg_t           pcfg,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    input  logic                rsp_stall,
    output logic                rsp_valid,
    output logic [STAT_W-1:0]   status,
    output logic [POOL_W-1:0]   granted_pool,
    output logic [BUF_W-1:0]    granted_buffer,
    output logic [CNT_W-1:0]    free_left
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_POP   = 5'b00010,
        S_SWEEP = 5'b00100,
        S_REL   = 5'b01000,
        S_CLEAR = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg [MAX_POOLS];
    logic [CNT_W-1:0]     count_next [MAX_POOLS];
    logic [SLOT_W-1:0]    sweep_reg, sweep_next;
    logic [POOL_W-1:0]    pool_reg, pool_next;
    logic [BUF_W-1:0]     bidx_reg, bidx_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    logic [POOL_W-1:0]    gpool_reg, gpool_next;
    logic [BUF_W-1:0]     gbuf_reg, gbuf_next;
    logic [CNT_W-1:0]     left_reg, left_next;

    // Free stack memory, one row per pool, no reset.
    logic [BUF_W-1:0]     stack_mem [SLOTS];
    logic [BUF_W-1:0]     rd_data_reg;
    logic                 mem_we, mem_re;
    logic [SLOT_W-1:0]    mem_waddr, mem_raddr;
    logic [BUF_W-1:0]     mem_wdata;

    // Owned flag memory, one flag per buffer, cleared by a pass after reset.
    logic                 owned_mem [SLOTS];
    logic                 own_rd_reg;
    logic                 own_we, own_re;
    logic [SLOT_W-1:0]    own_waddr, own_raddr;
    logic                 own_wdata;

    logic                 out_free, out_load;
    logic                 found, stop, do_pop;
    logic [POOL_W-1:0]    sel_pool, pop_pool;
    logic [CNT_W-1:0]     pop_cnt;
    logic [SLOT_W-1:0]    rel_slot;
    logic [CNT_W-1:0]     rel_cnt;
    logic [CNT_W-1:0]     hold_cnt;

    assign out_free = !out_valid_reg || !rsp_stall;

    // First pool large enough and non-empty; without look-to-next the scan
    // ends at the first pool that is large enough.
    always_comb
    begin
        found    = 1'b0;
        stop     = 1'b0;
        sel_pool = '0;
        for (int p = 0; p < MAX_POOLS; p++)
        begin
            if (!stop && q_cmd.fits[p])
            begin
                if (count_reg[p] != '0)
                begin
                    found    = 1'b1;
                    sel_pool = POOL_W'(p);
                    stop     = 1'b1;
                end
                else if (!q_cmd.look)
                begin
                    stop = 1'b1;
                end
            end
        end
    end

    assign pop_pool = (q_cmd.op == OP_ALLOC_SIZE) ? sel_pool : q_cmd.pool;
    assign pop_cnt  = count_reg[pop_pool] - 1'b1;
    assign rel_slot = {q_cmd.pool, q_cmd.bidx};
    assign rel_cnt  = count_reg[q_cmd.pool];
    assign hold_cnt = count_reg[pool_reg];

    // Sequencer: one word at a time, each started only with the output free.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sweep_next     = sweep_reg;
        pool_next      = pool_reg;
        bidx_next      = bidx_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_load       = 1'b0;
        status_next    = status_reg;
        gpool_next     = gpool_reg;
        gbuf_next      = gbuf_reg;
        left_next      = left_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        own_we         = 1'b0;
        own_waddr      = '0;
        own_wdata      = 1'b0;
        own_re         = 1'b0;
        own_raddr      = '0;
        q_pop          = 1'b0;
        do_pop         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop       = 1'b1;
                    status_next = ST_OK;
                    gpool_next  = '0;
                    gbuf_next   = '0;
                    left_next   = '0;
                    case (q_cmd.op)
                        OP_INIT:
                        begin
                            for (int p = 0; p < MAX_POOLS; p++)
                            begin
                                count_next[p] = (ACT_W'(p) < pcfg.active) ? pcfg.cap[p] : '0;
                            end
                            sweep_next = '0;
                            pool_next  = q_cmd.pool;
                            state_next = S_SWEEP;
                        end
                        OP_ALLOC_POOL:
                        begin
                            if (q_cmd.bad_pool)
                            begin
                                out_load    = 1'b1;
                                status_next = ST_BAD_POOL;
                            end
                            else if (count_reg[q_cmd.pool] == '0)
                            begin
                                out_load    = 1'b1;
                                status_next = ST_NONE_FREE;
                            end
                            else
                            begin
                                do_pop = 1'b1;
                            end
                        end
                        OP_ALLOC_SIZE:
                        begin
                            if (found)
                            begin
                                do_pop = 1'b1;
                            end
                            else
                            begin
                                out_load    = 1'b1;
                                status_next = ST_NONE_FREE;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (q_cmd.bad_pool)
                            begin
                                out_load    = 1'b1;
                                status_next = ST_BAD_POOL;
                            end
                            else if (q_cmd.bad_index)
                            begin
                                out_load    = 1'b1;
                                status_next = ST_BAD_INDEX;
                                left_next   = rel_cnt;
                            end
                            else
                            begin
                                // Read the owned flag, decide next cycle.
                                own_re     = 1'b1;
                                own_raddr  = rel_slot;
                                pool_next  = q_cmd.pool;
                                bidx_next  = q_cmd.bidx;
                                state_next = S_REL;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase

                    // Start of a pop: read the stack top, result next cycle.
                    if (do_pop)
                    begin
                        mem_re               = 1'b1;
                        mem_raddr            = {pop_pool, pop_cnt[BUF_W-1:0]};
                        count_next[pop_pool] = pop_cnt;
                        pool_next            = pop_pool;
                        state_next           = S_POP;
                    end
                end
            end
            S_POP:
            begin
                own_we      = 1'b1;
                own_waddr   = {pool_reg, rd_data_reg};
                own_wdata   = 1'b1;
                out_load    = 1'b1;
                status_next = ST_OK;
                gpool_next  = pool_reg;
                gbuf_next   = rd_data_reg;
                left_next   = count_reg[pool_reg];
                state_next  = S_IDLE;
            end
            S_REL:
            begin
                // Owned flag is back: push the buffer or report it not owned.
                out_load   = 1'b1;
                left_next  = hold_cnt;
                state_next = S_IDLE;
                if (!own_rd_reg)
                begin
                    status_next = ST_NOT_OWNED;
                end
                else
                begin
                    own_we    = 1'b1;
                    own_waddr = {pool_reg, bidx_reg};
                    own_wdata = 1'b0;
                    if (hold_cnt < CNT_W'(MAX_BUFFERS))
                    begin
                        mem_we               = 1'b1;
                        mem_waddr            = {pool_reg, hold_cnt[BUF_W-1:0]};
                        mem_wdata            = bidx_reg;
                        count_next[pool_reg] = hold_cnt + 1'b1;
                        left_next            = hold_cnt + 1'b1;
                    end
                end
            end
            S_SWEEP:
            begin
                // Every stack row is refilled with buffer numbers in order and
                // every owned flag is cleared.
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = sweep_reg[BUF_W-1:0];
                own_we     = 1'b1;
                own_waddr  = sweep_reg;
                own_wdata  = 1'b0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SLOT_W'(SLOTS - 1))
                begin
                    out_load    = 1'b1;
                    status_next = ST_OK;
                    gpool_next  = '0;
                    gbuf_next   = '0;
                    left_next   = (ACT_W'(pool_reg) < pcfg.active) ? count_reg[pool_reg] : '0;
                    state_next  = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                // After reset every owned flag is cleared before any word runs.
                own_we     = 1'b1;
                own_waddr  = sweep_reg;
                own_wdata  = 1'b0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            pool_reg      <= '0;
            bidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < MAX_POOLS; p++)
            begin
                count_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pool_reg      <= pool_next;
            bidx_reg      <= bidx_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Result word registers.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        gpool_reg  <= gpool_next;
        gbuf_reg   <= gbuf_next;
        left_reg   <= left_next;
    end

    // Free stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    // Owned flag memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            owned_mem[own_waddr] <= own_wdata;
        end
        if (own_re)
        begin
            own_rd_reg <= owned_mem[own_raddr];
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_pool   = gpool_reg;
    assign granted_buffer = gbuf_reg;
    assign free_left      = left_reg;

    // A new result must never overwrite one that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_load && out_valid_reg && rsp_stall))
        else $error("result overwritten while stalled");

    // A pop finishes in the cycle after its stack read.
    a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |=> state_reg == S_IDLE)
        else $error("pop did not complete in one cycle");

    // A release finishes in the cycle after its owned flag read.
    a_rel_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REL |=> state_reg == S_IDLE)
        else $error("release did not complete in one cycle");

    // No word leaves the queue during a sweep, a clear, a pop or a release.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !q_pop)
        else $error("queue popped while busy");

    // Free counts never exceed the pool capacity limit.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] <= CNT_W'(MAX_BUFFERS) && count_reg[1] <= CNT_W'(MAX_BUFFERS) &&
        count_reg[2] <= CNT_W'(MAX_BUFFERS) && count_reg[3] <= CNT_W'(MAX_BUFFERS))
        else $error("free count out of range");

endmodule

// ===== rtl/size_class_buffer_pool_allocator.sv =====
// ============================================================================
// Size-class buffer pool allocator
// Up to four pools of fixed-size buffers with last-in-first-out free lists,
// allocation by pool or by byte size, and checked release.
// ============================================================================
// Requests enter a front end that checks them against the configuration and
// land in a two-word queue, so the request side keeps accepting, until the
// queue is full, while the back end works and while a result waits for the
// stalled output. The back end takes one word at a time. A successful
// allocation waits on the registered read of the free stack memory; a release
// that passes the pool and index checks waits on the registered read of the
// owned flag memory; a release with a bad pool or buffer index and any failed
// allocation load the result straight from idle. An init sweeps all 256 stack
// entries and owned flags through the memories' single write ports. After
// reset the back end clears the owned flags before it takes its first word;
// the free stacks are not swept then, as they are only read where init or
// release has written them.
// Configuration writes are always taken and must only be made while idle.
module size_class_buffer_pool_allocator
    import scbpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]   cfg_data,
    // Request channel.
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [1:0]          operation,
    input  logic [POOL_W-1:0]   pool_index,
    input  logic [SIZE_W-1:0]   size_request,
    input  logic                look_to_next,
    input  logic [BUF_W-1:0]    buffer_index,
    // Result channel.
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STAT_W-1:0]   status,
    output logic [POOL_W-1:0]   granted_pool,
    output logic [BUF_W-1:0]    granted_buffer,
    output logic [CNT_W-1:0]    free_left
);

    logic [ACT_W-1:0]    pools_reg;
    logic [SIZES_W-1:0]  sizes_reg;
    logic [CAPS_W-1:0]   counts_reg;

    pool_cfg_t           pcfg;
    cmd_t                front_cmd;
    cmd_t                q_cmd;
    logic                q_full, q_valid, q_pop, q_push;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pools_reg  <= ACT_W'(1);
            sizes_reg  <= '0;
            counts_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POOLS_IN_USE: pools_reg  <= cfg_data[ACT_W-1:0];
                REG_BYTE_SIZES:   sizes_reg  <= cfg_data[SIZES_W-1:0];
                REG_BUF_COUNTS:   counts_reg <= cfg_data[CAPS_W-1:0];
                default:          pools_reg  <= pools_reg;
            endcase
        end
    end

    // Request acceptance into the queue.
    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    scbpa_front u_front (
        .pools_in_use       (pools_reg),
        .pool_byte_sizes    (sizes_reg),
        .pool_buffer_counts (counts_reg),
        .operation          (operation),
        .pool_index         (pool_index),
        .size_request       (size_request),
        .look_to_next       (look_to_next),
        .buffer_index       (buffer_index),
        .pcfg               (pcfg),
        .cmd                (front_cmd)
    );

    scbpa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    scbpa_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pcfg           (pcfg),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .rsp_stall      (rsp_stall),
        .rsp_valid      (rsp_valid),
        .status         (status),
        .granted_pool   (granted_pool),
        .granted_buffer (granted_buffer),
        .free_left      (free_left)
    );

endmodule
